### hw/rtl/sbt_pkg.sv
// Shared types and constants for the static B-tree lower-bound search block.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package sbt_pkg;

    // Default tree geometry
    localparam int KEYS_PER_NODE_DEF = 16;
    localparam int MAX_NODES_DEF     = 256;
    localparam int KEY_WIDTH_DEF     = 32;

    // Field widths fixed by the request format
    localparam int NODE_IDX_W   = 8;
    localparam int SLOT_W_FIELD = 4;
    localparam int KEY_FIELD_W  = 32;
    localparam int IN_TDATA_W   = 48;  // 8 + 4 + 32 = 44, padded to whole bytes
    localparam int OUT_TDATA_W  = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int NODE_CNT_W = 9;
    localparam int HEIGHT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_HEIGHT = 1'b1;

    // Request kinds carried in tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

### hw/rtl/static_btree_lower_bound.sv
// Lower-bound search over an implicit static B-tree held in on-chip memory.
// Depends on sbt_pkg for defaults, field widths and request/register codes.
`default_nettype none

// Block overview
// --------------
// The node keys live in one synchronous memory with one row per node; each row
// holds KEYS_PER_NODE keys of KEY_WIDTH bits in ascending order. A request with
// tuser = write stores key_value into slot `slot` of node `node_index` (requests
// outside the node or slot range are dropped) and completes with no response. A
// request with tuser = query walks the tree from node 0: for each of
// tree_height + 1 levels it reads one row (in the read state), compares all
// keys of the row against the search key in parallel (in the compare state), keeps
// the first key that is at least the search key, and descends into child
// k*(KEYS_PER_NODE+1)+i+1. The walk stops early when the node index reaches
// node_count or MAX_NODES. One response follows each query: tuser = found, tdata
// = the key kept at the last level that had one, or zero when no level did.
// A query keeps the block busy through a read state and a compare state per
// visited level, a final read state for the stop check, and the output state
// that hands off the response before it returns to idle; a write leaves the
// block in idle. The memory read latency and the row compare set the per-level
// cost. A finished response waits in an output register, so new requests are
// taken while it is still unread. Neither the request stream nor the
// configuration channel is ready during reset. Configuration writes are accepted
// every cycle out of reset; change node_count and tree_height only while no
// query is in flight. Keys are not cleared by reset: store every key a query can
// reach before querying.

module static_btree_lower_bound #(
    parameter int KEYS_PER_NODE = sbt_pkg::KEYS_PER_NODE_DEF,
    parameter int MAX_NODES     = sbt_pkg::MAX_NODES_DEF,
    parameter int KEY_WIDTH     = sbt_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    // Request stream
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // tdata: [7:0] node_index, [11:8] slot, [43:12] key_value (signed), [47:44] zero
    input  wire logic [sbt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: [0] command (0 write, 1 query)
    input  wire logic                             s_axis_tuser,

    // Response stream
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: [31:0] result_key (signed)
    output      logic [sbt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser: [0] found
    output      logic                             m_axis_tuser,

    // Configuration write channel
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [sbt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sbt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ADDR_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SLOT_W  = $clog2(KEYS_PER_NODE);
    localparam int IDX_W   = $clog2(KEYS_PER_NODE + 1);
    // Child index can reach MAX_NODES*(KEYS_PER_NODE+1) before the range check
    localparam int K_W     = $clog2(MAX_NODES * (KEYS_PER_NODE + 1) + 1);
    localparam int LEVEL_W = sbt_pkg::HEIGHT_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef logic [KEYS_PER_NODE-1:0][KEY_WIDTH-1:0] t_row;

    // Request fields
    logic [sbt_pkg::NODE_IDX_W-1:0]   in_node;
    logic [sbt_pkg::SLOT_W_FIELD-1:0] in_slot;
    logic [sbt_pkg::KEY_FIELD_W-1:0]  in_key_raw;
    logic [KEY_WIDTH-1:0]             in_key;

    assign in_node    = s_axis_tdata[7:0];
    assign in_slot    = s_axis_tdata[11:8];
    assign in_key_raw = s_axis_tdata[43:12];
    assign in_key     = KEY_WIDTH'($signed(in_key_raw));

    // Configuration registers
    logic [sbt_pkg::NODE_CNT_W-1:0] r_node_count;
    logic [sbt_pkg::HEIGHT_W-1:0]   r_tree_height;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count  <= '0;
            r_tree_height <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sbt_pkg::CFG_NODE_COUNT:  r_node_count  <= i_cfg_data;
                sbt_pkg::CFG_TREE_HEIGHT: r_tree_height <= i_cfg_data[sbt_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and walk state
    t_state               r_state, n_state;
    logic [K_W-1:0]       r_k, n_k;
    logic [LEVEL_W-1:0]   r_level;
    logic [KEY_WIDTH-1:0] r_target;
    logic                 r_found;
    logic [KEY_WIDTH-1:0] r_best;
    t_row                 r_rdata;

    // Output register
    logic                           r_m_valid;
    logic                           r_m_found;
    logic [sbt_pkg::OUT_TDATA_W-1:0] r_m_key;

    logic in_fire, wr_en, walk_go, out_load;

    // Hold off requests during reset so none is lost
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign wr_en = in_fire && (s_axis_tuser == sbt_pkg::CMD_WRITE)
                && (32'(in_node) < 32'(MAX_NODES))
                && (32'(in_slot) < 32'(KEYS_PER_NODE));

    // Continue while levels remain and the node lies inside the tree
    assign walk_go = (r_level <= {1'b0, r_tree_height})
                  && (32'(r_k) < 32'(r_node_count))
                  && (32'(r_k) < 32'(MAX_NODES));

    assign out_load = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    // Key memory: one node per row, slot-wide write, registered row read.
    // Writes happen only in idle and reads only while walking, so no overlap.
    t_row r_mem [MAX_NODES];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[ADDR_W'(in_node)][SLOT_W'(in_slot)] <= in_key;
        end
        if ((r_state == S_READ) && walk_go) begin
            r_rdata <= r_mem[r_k[ADDR_W-1:0]];
        end
    end

    // Row compare: first key at least the target
    logic [IDX_W-1:0]     hit_idx;
    logic                 hit;
    logic [KEY_WIDTH-1:0] hit_key;

    always_comb begin
        hit_idx = IDX_W'(KEYS_PER_NODE);
        hit     = 1'b0;
        hit_key = '0;
        for (int j = KEYS_PER_NODE - 1; j >= 0; j--) begin
            if ($signed(r_rdata[j]) >= $signed(r_target)) begin
                hit_idx = IDX_W'(j);
                hit     = 1'b1;
                hit_key = r_rdata[j];
            end
        end
    end

    assign n_k = K_W'(r_k * K_W'(KEYS_PER_NODE + 1)) + K_W'(hit_idx) + K_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_fire && (s_axis_tuser == sbt_pkg::CMD_QUERY)) n_state = S_READ;
            S_READ: n_state = walk_go ? S_CMP : S_OUT;
            S_CMP:  n_state = S_READ;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_k      <= '0;
            r_level  <= '0;
            r_target <= in_key;
            r_found  <= 1'b0;
            r_best   <= '0;
        end else if (r_state == S_CMP) begin
            r_k     <= n_k;
            r_level <= r_level + LEVEL_W'(1);
            if (hit) begin
                r_found <= 1'b1;
                r_best  <= hit_key;
            end
        end
    end

    // Response register: hold until taken, load when free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_found <= r_found;
            r_m_key   <= r_found ? sbt_pkg::OUT_TDATA_W'(r_best) : '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_found;
    assign m_axis_tdata  = r_m_key;

endmodule

`default_nettype wire

### hw/rtl/sbt_checker.sv
// Port-level checker for the static B-tree search block, bound to the top level.
// Depends on sbt_pkg for the request codes and the response width.
`default_nettype none

module sbt_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             s_axis_tuser,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [sbt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                             m_axis_tuser
);

    // Reset empties the response register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("response valid after reset");

    // A miss carries a zero key
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss response with nonzero key");

    // After a query is taken, the block is not ready in the following cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == sbt_pkg::CMD_QUERY))
        |=> !s_axis_tready)
        else $error("request taken right after a query");

    // Hold a stalled response
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("response dropped while stalled");

endmodule

bind static_btree_lower_bound sbt_checker u_sbt_checker (.*);

`default_nettype wire

### verif/sbt_lb_checker.sv
// Scoreboard for the static B-tree lower-bound block: watches the request, response
// and configuration channels, keeps its own copy of the key store and geometry,
// and predicts each query answer. Depends on sbt_pkg for widths and codes.

module sbt_lb_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    input  wire logic [sbt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tuser,
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic [sbt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                             m_axis_tuser,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             o_cfg_ready,
    input  wire logic [sbt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sbt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_answer_count,
    output int                                    o_found_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_KEYS = sbt_pkg::KEYS_PER_NODE_DEF;
    localparam int ROWS     = sbt_pkg::MAX_NODES_DEF;

    typedef logic signed [sbt_pkg::KEY_WIDTH_DEF-1:0] t_key;
    typedef struct packed {
        logic found;
        t_key key;
        t_key probe;
    } t_bound;

    t_key                          key_mem [ROWS*ROW_KEYS];
    logic [sbt_pkg::NODE_CNT_W-1:0] nodes_in_use;
    logic [sbt_pkg::HEIGHT_W-1:0]   walk_height;
    t_bound                        bound_q [$];
    int                            fails    = 0;
    int                            answers  = 0;
    int                            hits     = 0;

    // Walk the tree from the root, keeping the first key >= probe at each level.
    function automatic t_bound lower_bound(input t_key probe);
        t_bound r;
        int     limit;
        int     k;
        int     i;
        r       = '0;
        r.probe = probe;
        limit   = (nodes_in_use < ROWS) ? int'(nodes_in_use) : ROWS;
        k       = 0;
        for (int lvl = 0; lvl <= int'(walk_height); lvl++) begin
            if (k >= limit) break;
            i = 0;
            while (i < ROW_KEYS && key_mem[k*ROW_KEYS+i] < probe) i++;
            if (i < ROW_KEYS) begin
                r.found = 1'b1;
                r.key   = key_mem[k*ROW_KEYS+i];
            end
            k = k * (ROW_KEYS + 1) + i + 1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_bound want;
        if (!i_rst_n) begin
            nodes_in_use = '0;
            walk_height  = '0;
            bound_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                answers++;
                if (m_axis_tuser) hits++;
                if (bound_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected answer: found=%0b key=%0d",
                                 m_axis_tuser, $signed(m_axis_tdata));
                end else begin
                    want = bound_q.pop_front();
                    if (m_axis_tuser !== want.found || m_axis_tdata !== want.key) begin
                        fails++;
                        if (fails <= 10)
                            $display("answer mismatch for probe %0d: expected found=%0b key=%0d, got found=%0b key=%0d",
                                     $signed(want.probe), want.found, $signed(want.key),
                                     m_axis_tuser, $signed(m_axis_tdata));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == sbt_pkg::CMD_WRITE)
                    key_mem[int'(s_axis_tdata[7:0])*ROW_KEYS + int'(s_axis_tdata[11:8])]
                        = s_axis_tdata[43:12];
                else
                    bound_q.push_back(lower_bound(s_axis_tdata[43:12]));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sbt_pkg::CFG_NODE_COUNT:  nodes_in_use = i_cfg_data;
                    sbt_pkg::CFG_TREE_HEIGHT: walk_height  = i_cfg_data[sbt_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending      <= bound_q.size();
        o_fail_count   <= fails;
        o_answer_count <= answers;
        o_found_count  <= hits;
    end

endmodule

### verif/tb_static_btree_lower_bound.sv
// Top of the lower-bound search testbench: clock, reset, request/response/config
// stimulus with random idling, and the verdict. Depends on sbt_pkg, the block
// static_btree_lower_bound and the scoreboard sbt_lb_checker.

module tb_static_btree_lower_bound;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_KEYS      = sbt_pkg::KEYS_PER_NODE_DEF;
    localparam int ROWS          = sbt_pkg::MAX_NODES_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1500000;

    typedef logic signed [sbt_pkg::KEY_WIDTH_DEF-1:0] t_key;

    localparam t_key KEY_MAX = 32'sh7FFF_FFFF;
    localparam t_key KEY_MIN = 32'sh8000_0000;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [sbt_pkg::IN_TDATA_W-1:0]   s_axis_tdata;   // node_index, slot, key_value, zero pad
    logic                             s_axis_tuser;   // command
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [sbt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;   // result_key
    logic                             m_axis_tuser;   // found
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [sbt_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [sbt_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    int fail_count;
    int answers_owed;
    int answer_count;
    int found_count;

    // Stimulus-side view of the key store, used to aim probes and rewrites at stored keys
    t_key shadow [ROWS*ROW_KEYS];
    bit   row_ready [ROWS];
    t_key row_buf [ROW_KEYS];

    int cycles      = 0;
    int writes_sent = 0;
    int queries_sent = 0;
    int shapes_used = 0;
    int send_calm   = 0;
    int hold_asks   = 0;
    bit quiet       = 1'b0;

    static_btree_lower_bound u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sbt_lb_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (answers_owed),
        .o_answer_count (answer_count),
        .o_found_count  (found_count)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: end the run if the answers never drain
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Response side: random stall bursts, calm stretches, and on request one long
    // hold-off so the block fills up and pushes back on the request stream.
    initial begin : response_side
        int calm;
        int holds_done;
        calm       = 0;
        holds_done = 0;
        @(posedge i_clk);
        forever begin
            if (holds_done != hold_asks) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && calm == 0 && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                if ($urandom_range(0, 7) == 0) calm = $urandom_range(20, 80);
            end else begin
                m_axis_tready <= 1'b1;
                if (calm > 0) calm--;
                @(posedge i_clk);
            end
        end
    end

    // Offer one request and hold it until the block takes it. An idle burst may
    // come first; valid is never dropped and raised in the same step.
    task automatic send_req(input logic cmd, input logic [7:0] node,
                            input logic [3:0] slot, input t_key key);
        if (!quiet && send_calm == 0 && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
            if ($urandom_range(0, 7) == 0) send_calm = $urandom_range(20, 80);
        end else if (send_calm > 0) begin
            send_calm--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0000, key, slot, node};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (cmd == sbt_pkg::CMD_WRITE) begin
            shadow[int'(node)*ROW_KEYS + int'(slot)] = key;
            writes_sent++;
        end else begin
            queries_sent++;
        end
    endtask

    task automatic ask(input t_key probe);
        send_req(sbt_pkg::CMD_QUERY, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), probe);
    endtask

    // Store row_buf as node k
    task automatic write_row(input int k);
        for (int s = 0; s < ROW_KEYS; s++)
            send_req(sbt_pkg::CMD_WRITE, 8'(k), 4'(s), row_buf[s]);
        row_ready[k] = 1'b1;
    endtask

    // Give every node a query can reach a full sorted row, some padded with KEY_MAX
    task automatic fill_rows(input int nc);
        int   last;
        int   style;
        int   base;
        int   pad;
        int   j;
        t_key v;
        last = (nc > ROWS) ? ROWS : nc;
        for (int k = 0; k < last; k++) begin
            if (!row_ready[k]) begin
                style = $urandom_range(0, 3);
                base  = int'($urandom_range(0, 4000)) - 2000;
                pad   = (style == 2) ? $urandom_range(1, 15) : 0;
                for (int s = 0; s < ROW_KEYS; s++)
                    row_buf[s] = (style == 1) ? t_key'($urandom)
                                              : t_key'(base + int'($urandom_range(0, 400)));
                if (style == 3) row_buf[0] = KEY_MIN;
                for (int a = 1; a < ROW_KEYS; a++) begin
                    v = row_buf[a];
                    j = a - 1;
                    while (j >= 0 && row_buf[j] > v) begin
                        row_buf[j+1] = row_buf[j];
                        j--;
                    end
                    row_buf[j+1] = v;
                end
                for (int s = ROW_KEYS - pad; s < ROW_KEYS; s++) row_buf[s] = KEY_MAX;
                write_row(k);
            end
        end
    endtask

    // Half the time aim near stored keys (equal, one below, one above); otherwise
    // narrow random, full random, the extremes, -1 and 0.
    function automatic t_key pick_probe(input int nc);
        int   span;
        int   pick;
        t_key v;
        span = (nc > ROWS) ? ROWS : ((nc > 0) ? nc : 1);
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            v = shadow[$urandom_range(0, span - 1) * ROW_KEYS + $urandom_range(0, ROW_KEYS - 1)];
            v = v + t_key'(int'($urandom_range(0, 2)) - 1);
        end else if (pick < 7) begin
            v = t_key'(int'($urandom_range(0, 4600)) - 2300);
        end else if (pick < 9) begin
            v = t_key'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0:       v = KEY_MIN;
                1:       v = KEY_MAX;
                2:       v = -1;
                default: v = 0;
            endcase
        end
        return v;
    endfunction

    // Random traffic: mostly queries, some key rewrites anywhere in the store
    task automatic run_mix(input int count, input int nc);
        int   node;
        int   slot;
        t_key v;
        repeat (count) begin
            if ($urandom_range(0, 9) < 2) begin
                node = $urandom_range(0, ROWS - 1);
                slot = $urandom_range(0, ROW_KEYS - 1);
                if ($urandom_range(0, 1) == 1)
                    v = t_key'($urandom);
                else
                    v = shadow[node*ROW_KEYS + slot] + t_key'(int'($urandom_range(0, 6)) - 3);
                send_req(sbt_pkg::CMD_WRITE, 8'(node), 4'(slot), v);
            end else begin
                ask(pick_probe(nc));
            end
        end
    endtask

    // Drop the request stream, wait until every answer is in, then let
    // SETTLE_CYCLES pass
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (answers_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reprogram the geometry while the block is idle; keep valid high across
    // both register writes. Upper bits of the height write are junk on purpose.
    task automatic set_tree(input int nc, input int th);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sbt_pkg::CFG_NODE_COUNT;
        i_cfg_data  <= 9'(nc);
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_index <= sbt_pkg::CFG_TREE_HEIGHT;
        i_cfg_data  <= {6'($urandom_range(0, 63)), 3'(th)};
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        shapes_used++;
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = sbt_pkg::CMD_WRITE;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = sbt_pkg::CFG_NODE_COUNT;
        i_cfg_data    = '0;
        foreach (shadow[j]) shadow[j] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Root only: a hand-made row with both extremes and KEY_MAX padding
        set_tree(1, 0);
        row_buf = '{KEY_MIN, -1000, -1, 0, 1, 7, 100, 5000, 70000, KEY_MAX - 1,
                    KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX};
        write_row(0);
        send_req(sbt_pkg::CMD_WRITE, 8'hFF, 4'hF, KEY_MIN);   // top node, top slot
        ask(KEY_MIN);
        ask(KEY_MAX);          // only the padding matches
        ask(-1);
        ask(-2);
        ask(2);
        ask(70001);
        ask(KEY_MAX - 1);
        ask(0);
        run_mix(100, 1);

        // Empty tree: every walk leaves at once
        set_tree(0, 7);
        ask(0);
        ask(KEY_MIN);
        run_mix(60, 0);

        // Two levels; root with no padding so large probes fall to the last child
        set_tree(18, 1);
        fill_rows(18);
        for (int s = 0; s < ROW_KEYS; s++) row_buf[s] = t_key'(100 * s);
        write_row(0);
        for (int s = 0; s < ROW_KEYS; s++) row_buf[s] = t_key'(2000 + 100 * s);
        write_row(17);
        ask(1600);             // nothing at the root, found in the last child
        ask(4000);             // nothing anywhere
        ask(50);
        ask(KEY_MAX);
        run_mix(120, 18);

        // Tallest height over a partial third level; hold off the response side
        set_tree(20, 7);
        fill_rows(20);
        hold_asks <= hold_asks + 1;
        run_mix(250, 20);

        // Few nodes: most second-level children lie outside the tree
        set_tree(5, 3);
        run_mix(120, 5);

        // Node count beyond the store size
        set_tree(511, 1);
        run_mix(100, 18);

        // Last stretch runs without idling on either side
        quiet <= 1'b1;
        set_tree(256, 0);
        run_mix(150, 256);

        settle();
        $display("Sent %0d key writes and %0d lower-bound queries over %0d tree shapes.",
                 writes_sent, queries_sent, shapes_used);
        $display("Checked %0d answers, %0d with a key found; %0d mismatches.",
                 answer_count, found_count, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
